@@ rtl/core/msft_pkg.sv @@
// Shared types and codes for the maximal set facet table.
package msft_pkg;

	// Fixed field widths
	localparam int MASK_W  = 32;
	localparam int PC_W    = 6;
	localparam int FIELD_W = 7;

	localparam logic [PC_W-1:0] PC_RESET = 6'd32;

	// Result status codes
	localparam logic [1:0] STAT_STORED   = 2'd0;
	localparam logic [1:0] STAT_ABSORBED = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	// Sweep kinds carried by the scan token
	localparam logic PASS_ABS = 1'b0;
	localparam logic PASS_INS = 1'b1;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic vld;
		logic pass;
		logic flag;	// absorbed (absorb sweep) or placed (insert sweep)
	} tok_t;

endpackage

@@ rtl/core/msft_cell.sv @@
// One table slot: a stored facet, its valid bit and one stage of the scan token.
module msft_cell #(
	parameter int CW = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [31:0]             item_mask,
	input  msft_pkg::tok_t          tok_in,
	input  logic [CW-1:0]           cnt_in,
	output msft_pkg::tok_t          tok_out,
	output logic [CW-1:0]           cnt_out
);
	import msft_pkg::*;

	logic [MASK_W-1:0] mask_q;
	logic              valid_q;
	tok_t              tok_q;
	logic [CW-1:0]     cnt_q;

	logic              hit_abs;
	logic              hit_sub;
	logic              valid_nxt;
	logic              write_en;
	tok_t              tok_nxt;
	logic [CW-1:0]     cnt_nxt;

	// Compare the offered set against this slot both ways
	assign hit_abs = valid_q && ((item_mask & ~mask_q) == '0);
	assign hit_sub = valid_q && ((mask_q & ~item_mask) == '0);

	// Update the token and the slot as the token passes
	always_comb begin
		tok_nxt   = tok_in;
		cnt_nxt   = cnt_in;
		valid_nxt = valid_q;
		write_en  = 1'b0;
		if (tok_in.vld && tok_in.pass == PASS_ABS) begin
			tok_nxt.flag = tok_in.flag | hit_abs;
		end
		if (tok_in.vld && tok_in.pass == PASS_INS) begin
			// drop a facet that the new set contains
			if (hit_sub) begin
				valid_nxt = 1'b0;
				cnt_nxt   = cnt_in + CW'(1);
			end
			// take the set into the lowest free slot
			if ((!valid_q || hit_sub) && !tok_in.flag) begin
				valid_nxt    = 1'b1;
				write_en     = 1'b1;
				tok_nxt.flag = 1'b1;
			end
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			valid_q <= valid_nxt;
			tok_q   <= tok_nxt;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (write_en) begin
			mask_q <= item_mask;
		end
		cnt_q <= cnt_nxt;
	end

	assign tok_out = tok_q;
	assign cnt_out = cnt_q;

endmodule

@@ rtl/core/maximal_set_facet_table_top.sv @@
// Top level of the maximal set facet table: control, range check and the cell chain.
//
// Input beats on s_* carry one point set each; output beats on m_* carry one
// result per set: status in m_tuser, removed and held facet counts in m_tdata.
// cfg_* writes point_count; write only while no set is in flight.
//
// Each slot is one cell of a chain. A scan token walks the chain one cell a
// cycle: the first sweep looks for a stored facet that contains the set, the
// second drops the facets that the set contains, counts them and stores the
// set in the lowest free slot. An absorbed set skips the second sweep and a set
// with a point out of range skips both. s_tready returns high at the edge that
// loads the result, and one set is in work at a time.
// The result waits in an output register while the next set is accepted;
// a stalled receiver holds a finished set only until the register frees.
// Reset empties the table at once and sets point_count to 32.
module maximal_set_facet_table_top #(
	parameter int MAX_POINTS = 32,
	parameter int MAX_FACETS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,	// [31:0] point_mask
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,	// [6:0] removed_count, [13:7] facet_count, [15:14] zero
	output logic [1:0]  m_tuser,	// [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data	// point_count
);
	import msft_pkg::*;

	localparam int CW      = $clog2(MAX_FACETS + 1);
	localparam int LIM_CAP = (MAX_POINTS < MASK_W) ? MAX_POINTS : MASK_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ABS  = 2'd1;
	localparam logic [1:0] S_INS  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [PC_W-1:0]   pc_q;
	logic [MASK_W-1:0] mask_q;
	logic [CW-1:0]     count_q;
	tok_t              launch_q;
	logic [1:0]        res_status_q;
	logic [CW-1:0]     res_removed_q;
	logic              m_tvalid_q;
	logic [1:0]        m_status_q;
	logic [FIELD_W-1:0] m_removed_q;
	logic [FIELD_W-1:0] m_facets_q;

	logic [6:0]        lim;
	logic [MASK_W-1:0] allow;
	logic              range_bad;
	logic              in_acc;
	logic              out_load;

	tok_t              tok_w [MAX_FACETS+1];
	logic [CW-1:0]     cnt_w [MAX_FACETS+1];

	// Effective point limit and range check of the offered set
	always_comb begin
		lim = {1'b0, pc_q};
		if (lim > 7'(LIM_CAP)) begin
			lim = 7'(LIM_CAP);
		end
		for (int k = 0; k < MASK_W; k++) begin
			allow[k] = 7'(k) < lim;
		end
	end
	assign range_bad = (s_tdata & ~allow) != '0;

	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_load  = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;

	// Chain of slot cells
	assign tok_w[0] = launch_q;
	assign cnt_w[0] = '0;
	for (genvar g = 0; g < MAX_FACETS; g++) begin : g_cell
		msft_cell #(.CW(CW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.item_mask (mask_q),
			.tok_in    (tok_w[g]),
			.cnt_in    (cnt_w[g]),
			.tok_out   (tok_w[g+1]),
			.cnt_out   (cnt_w[g+1])
		);
	end

	// Launch a sweep token for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else if (in_acc && !range_bad) begin
			launch_q <= '{vld: 1'b1, pass: PASS_ABS, flag: 1'b0};
		end else if (state_q == S_ABS && tok_w[MAX_FACETS].vld
				&& !tok_w[MAX_FACETS].flag) begin
			launch_q <= '{vld: 1'b1, pass: PASS_INS, flag: 1'b0};
		end else begin
			launch_q <= '0;
		end
	end

	// Sequence the sweeps and keep the facet count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= PC_RESET;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (range_bad) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_ABS;
						end
					end
				end
				S_ABS: begin
					if (tok_w[MAX_FACETS].vld) begin
						if (tok_w[MAX_FACETS].flag) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					if (tok_w[MAX_FACETS].vld) begin
						count_q <= count_q - cnt_w[MAX_FACETS]
							+ CW'(tok_w[MAX_FACETS].flag);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// advance the output register
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Capture the set and its result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mask_q        <= s_tdata;
			res_status_q  <= STAT_RANGE;
			res_removed_q <= '0;
		end
		if (state_q == S_ABS && tok_w[MAX_FACETS].vld) begin
			res_status_q  <= STAT_ABSORBED;
			res_removed_q <= '0;
		end
		if (state_q == S_INS && tok_w[MAX_FACETS].vld) begin
			res_status_q  <= tok_w[MAX_FACETS].flag ? STAT_STORED : STAT_FULL;
			res_removed_q <= cnt_w[MAX_FACETS];
		end
		if (out_load) begin
			m_status_q  <= res_status_q;
			m_removed_q <= FIELD_W'(res_removed_q);
			m_facets_q  <= FIELD_W'(count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {2'b00, m_facets_q, m_removed_q};

endmodule

@@ rtl/core/msft_checker.sv @@
// Port-level checks for the maximal set facet table, bound to the top level.
module msft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import msft_pkg::*;

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Only a stored set may remove facets
	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_ABSORBED || m_tuser == STAT_RANGE
			|| m_tuser == STAT_FULL) |-> m_tdata[6:0] == 7'd0)
		else $error("removed count nonzero without a store");

	// One set in work at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second set accepted while one is in work");

	// No result appears in the cycle right after an accept
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind maximal_set_facet_table_top msft_checker u_msft_checker (.*);
